// ----- src/ins_sort_pkg.sv -----
// Shared types for the insertion sorter: controller commands, datapath status, FSM states.
`timescale 1ns / 1ps

package ins_sort_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [0:0] {
      ST_LOAD = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic load;     // insert req value into the cell chain
      logic unload;   // shift the chain down one place, drop one from the count
   } cmd_type;

   typedef struct packed {
      logic full;     // count has reached the chain depth
      logic last_one; // exactly one item left in the chain
   } status_type;

endpackage

// ----- src/ins_sort_dp.sv -----
// Datapath: a row of compare-and-shift cells holding the sorted set, plus the item count.
`timescale 1ns / 1ps

module ins_sort_dp #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ins_sort_pkg::cmd_type                     cmd,
   input  logic signed [ins_sort_pkg::VALUE_W-1:0]   value,
   output ins_sort_pkg::status_type                  status,
   output logic signed [ins_sort_pkg::VALUE_W-1:0]   head
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic signed [ins_sort_pkg::VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [ins_sort_pkg::VALUE_W-1:0] cell_in [DEPTH];
   logic [DEPTH-1:0] greater;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [ins_sort_pkg::VALUE_W-1:0] from_below;
         logic signed [ins_sort_pkg::VALUE_W-1:0] from_above;
         logic below_greater;
         logic at_end;

         // Only occupied cells take part in the compare.
         assign greater[i] = (CW'(i) < count_ff) && (cell_ff[i] > value);
         assign at_end     = (CW'(i) == count_ff);

         if (i == 0) begin : g_first
            assign from_below    = value;
            assign below_greater = 1'b0;
         end else begin : g_rest
            assign from_below    = cell_ff[i-1];
            assign below_greater = greater[i-1];
         end

         if (i == DEPTH - 1) begin : g_top
            assign from_above = cell_ff[i];
         end else begin : g_mid
            assign from_above = cell_ff[i+1];
         end

         always_comb begin
            cell_in[i] = cell_ff[i];
            if (cmd.unload) begin
               cell_in[i] = from_above;
            end else if (cmd.load) begin
               // Greater entries move up; the new item fills the gap after any equal ones.
               if (below_greater) begin
                  cell_in[i] = from_below;
               end else if (greater[i] || at_end) begin
                  cell_in[i] = value;
               end
            end
         end

         always_ff @(posedge clock) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.unload) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.load) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.full     = (count_ff == CW'(DEPTH));
   assign status.last_one = (count_ff == CW'(1));
   assign head            = cell_ff[0];

endmodule

// ----- src/ins_sort_ctrl.sv -----
// Controller: load phase takes items, emit phase drains the chain one item per cycle.
`timescale 1ns / 1ps

module ins_sort_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_is_last,
   input  ins_sort_pkg::status_type  status,
   output ins_sort_pkg::cmd_type     cmd,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic                      rsp_end_of_set
);

   ins_sort_pkg::state_type state_ff;
   ins_sort_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ins_sort_pkg::ST_LOAD: begin
            if (start && req_is_last) begin
               state_in = ins_sort_pkg::ST_EMIT;
            end
         end
         ins_sort_pkg::ST_EMIT: begin
            if (status.last_one) begin
               state_in = ins_sort_pkg::ST_LOAD;
            end
         end
         default: state_in = ins_sort_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ins_sort_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd            = '0;
      busy           = 1'b0;
      rsp_valid      = 1'b0;
      rsp_end_of_set = 1'b0;
      unique case (state_ff)
         ins_sort_pkg::ST_LOAD: begin
            // A full chain drops the item; its last flag still acts.
            cmd.load = start && !status.full;
         end
         ins_sort_pkg::ST_EMIT: begin
            busy           = 1'b1;
            rsp_valid      = 1'b1;
            rsp_end_of_set = status.last_one;
            cmd.unload     = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- src/insertion_sorter_top.sv -----
// Top level of the insertion sorter: controller and cell-chain datapath.
`timescale 1ns / 1ps

// Takes one signed value per item, one item per cycle while busy is low, and inserts
// it into a sorted chain of DEPTH compare-and-shift cells. Items arriving with the
// chain full are dropped, but their last flag still counts. The item with req_is_last
// set ends the set: busy rises the next cycle and the block emits the N stored values
// in non-decreasing order on consecutive cycles, one per rsp_valid strobe, with
// rsp_end_of_set on the final one. Equal values leave in arrival order. The receiver
// cannot stall; the emit phase is set by the chain shifting out one cell per cycle.
// When the emit phase ends, the count is zero.
module insertion_sorter_top #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [ins_sort_pkg::VALUE_W-1:0]  req_value,
   input  logic                                     req_is_last,
   output logic                                     rsp_valid,
   output logic signed [ins_sort_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                                     rsp_end_of_set
);

   ins_sort_pkg::cmd_type    cmd;
   ins_sort_pkg::status_type status;

   ins_sort_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_is_last    (req_is_last),
      .status         (status),
      .cmd            (cmd),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_end_of_set (rsp_end_of_set)
   );

   ins_sort_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .value  (req_value),
      .status (status),
      .head   (rsp_sorted_value)
   );

endmodule

// ----- tb/insertion_sorter_top_tb.sv -----
// Self-checking testbench for insertion_sorter_top: directed table, random sets, ordered check.
`timescale 1ns / 1ps

module insertion_sorter_top_tb;

   localparam int unsigned DEPTH       = 64;
   localparam int          RAND_ITEMS  = 158;
   localparam int          STALL_LIMIT = 4000;
   localparam int          IDLE_PCT    = 36;

   localparam logic signed [ins_sort_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [ins_sort_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [ins_sort_pkg::VALUE_W-1:0] value;
      logic                                    eos;
   } sorted_item_type;

   typedef struct packed {
      logic signed [ins_sort_pkg::VALUE_W-1:0] value;
      logic                                    last;
      logic                                    typed;  // expected result written out below
      logic signed [ins_sort_pkg::VALUE_W-1:0] want;   // only single-item sets are typed
   } stim_row_type;

   localparam int N_ROWS = 22;
   localparam stim_row_type STIM [N_ROWS] = '{
      // single-item sets: the one result is the value itself, end flag set
      '{VAL_MIN,         1'b1, 1'b1, VAL_MIN},
      '{VAL_MAX,         1'b1, 1'b1, VAL_MAX},
      '{32'sd0,          1'b1, 1'b1, 32'sd0},
      '{-32'sd1,         1'b1, 1'b1, -32'sd1},
      // extremes mixed together
      '{VAL_MAX,         1'b0, 1'b0, 32'sd0},
      '{32'sd0,          1'b0, 1'b0, 32'sd0},
      '{VAL_MIN,         1'b0, 1'b0, 32'sd0},
      '{-32'sd1,         1'b0, 1'b0, 32'sd0},
      '{32'sd1,          1'b1, 1'b0, 32'sd0},
      // duplicates keep arrival order
      '{32'sd7,          1'b0, 1'b0, 32'sd0},
      '{-32'sd3,         1'b0, 1'b0, 32'sd0},
      '{32'sd7,          1'b0, 1'b0, 32'sd0},
      '{-32'sd3,         1'b1, 1'b0, 32'sd0},
      // descending: every insert shifts the whole store
      '{32'sd40,         1'b0, 1'b0, 32'sd0},
      '{32'sd30,         1'b0, 1'b0, 32'sd0},
      '{32'sd20,         1'b0, 1'b0, 32'sd0},
      '{32'sd10,         1'b1, 1'b0, 32'sd0},
      // ascending: nothing shifts; then an alternating-bit pair whose negative second item shifts the first
      '{-32'sd9,         1'b0, 1'b0, 32'sd0},
      '{-32'sd8,         1'b0, 1'b0, 32'sd0},
      '{-32'sd7,         1'b1, 1'b0, 32'sd0},
      '{32'sh5555_5555,  1'b0, 1'b0, 32'sd0},
      '{32'shAAAA_AAAA,  1'b1, 1'b0, 32'sd0}
   };

   logic                                    clock       = 1'b0;
   logic                                    reset       = 1'b1;
   logic                                    start       = 1'b0;
   logic signed [ins_sort_pkg::VALUE_W-1:0] req_value   = '0;
   logic                                    req_is_last = 1'b0;
   logic                                    busy;
   logic                                    rsp_valid;
   logic signed [ins_sort_pkg::VALUE_W-1:0] rsp_sorted_value;
   logic                                    rsp_end_of_set;

   // typed expectation travels with the item
   logic                                    row_typed = 1'b0;
   logic signed [ins_sort_pkg::VALUE_W-1:0] row_want  = '0;

   sorted_item_type                         sorted_due[$];
   sorted_item_type                         set_out[$];
   logic signed [ins_sort_pkg::VALUE_W-1:0] sort_store [DEPTH];
   int                                      held         = 0;
   int                                      errors       = 0;
   int                                      items_sent   = 0;
   int                                      stall_cycles = 0;
   bit                                      no_idle      = 1'b0;

   insertion_sorter_top #(.DEPTH(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Insert into the sorted store; on the last item, dump the set into set_out.
   task automatic sort_insert(input logic signed [ins_sort_pkg::VALUE_W-1:0] v,
                              input logic last);
      int pos;
      set_out.delete();
      if (held < DEPTH) begin
         pos = held;
         while (pos > 0 && sort_store[pos-1] > v) begin
            sort_store[pos] = sort_store[pos-1];
            pos--;
         end
         sort_store[pos] = v;
         held++;
      end
      if (last) begin
         for (int k = 0; k < held; k++)
            set_out.push_back(sorted_item_type'{sort_store[k], (k == held - 1)});
         held = 0;
      end
   endtask

   always @(posedge clock) begin : check_sorted
      sorted_item_type want;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            moved = 1'b1;
            if (sorted_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual value %0d end %0b",
                        $time, rsp_sorted_value, rsp_end_of_set);
               errors++;
            end else begin
               want = sorted_due.pop_front();
               if (rsp_sorted_value !== want.value) begin
                  $display("%0t: sorted_value expected %0d actual %0d",
                           $time, $signed(want.value), rsp_sorted_value);
                  errors++;
               end
               if (rsp_end_of_set !== want.eos) begin
                  $display("%0t: end_of_set expected %0b actual %0b",
                           $time, want.eos, rsp_end_of_set);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            sort_insert(req_value, req_is_last);
            if (row_typed)
               sorted_due.push_back(sorted_item_type'{row_want, 1'b1});
            else
               foreach (set_out[k]) sorted_due.push_back(set_out[k]);
         end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_item(input logic signed [ins_sort_pkg::VALUE_W-1:0] v,
                            input logic last, input logic typed,
                            input logic signed [ins_sort_pkg::VALUE_W-1:0] want);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start       <= 1'b1;
      req_value   <= v;
      req_is_last <= last;
      row_typed   <= typed;
      row_want    <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Sample mid-cycle so the items pushed at the accepting edge are already queued.
   task automatic wait_drained();
      @(negedge clock);
      while (sorted_due.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [ins_sort_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $signed($urandom_range(8)) - 4;  // dense duplicates
         6:          return $urandom_range(1) ? VAL_MAX : VAL_MIN;
         7:          return VAL_MIN + $urandom_range(3);
         8:          return VAL_MAX - $urandom_range(3);
         default:    return $urandom & 32'h8000_00FF;
      endcase
   endfunction

   function automatic int pick_set_len(input int set_no);
      int r;
      r = $urandom_range(99);
      if (set_no == 0) return DEPTH + 3;  // overflow: extra items dropped
      if (set_no == 1) return DEPTH;      // exactly full
      if (r < 70) return $urandom_range(8, 1);
      if (r < 92) return $urandom_range(32, 9);
      return $urandom_range(DEPTH + 4, 33);
   endfunction

   initial begin : stimulus
      int set_len;
      int set_no;
      int goal;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++)
         send_item(STIM[r].value, STIM[r].last, STIM[r].typed, STIM[r].want);
      start <= 1'b0;
      wait_drained();

      goal   = items_sent + RAND_ITEMS;
      set_no = 0;
      while (items_sent < goal) begin
         set_len = pick_set_len(set_no);
         if (set_len > goal - items_sent)
            set_len = goal - items_sent;
         no_idle = (set_no >= 6 && set_no < 12);
         for (int i = 0; i < set_len; i++)
            send_item(pick_value(), (i == set_len - 1), 1'b0, '0);
         if ($urandom_range(7) == 0) begin
            start <= 1'b0;
            wait_drained();
         end
         set_no++;
      end
      start <= 1'b0;

      wait_drained();
      repeat (DEPTH + 8) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
